// ===== hdl/ccp_pkg.sv =====
// Shared types, codes and reset values for the compressor cycle protection block.
// Used by ccp_cfg_regs, ccp_core and compressor_cycle_protection_fsm.
package ccp_pkg;

    // Field and register widths
    localparam int TIMER_WIDTH_DEF = 24;
    localparam int CMD_W           = 3;
    localparam int TEMP_W          = 12;
    localparam int MODE_W          = 3;
    localparam int RUN_W           = 32;
    localparam int TICK_W          = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TEMP   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FAULT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOCK   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNLOCK = 3'd5;
    localparam logic [CMD_W-1:0] CMD_REPORT = 3'd6;

    // Controller modes
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WORK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READY = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REST  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONT  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_FAULT = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POWER_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd5;

    // Register reset values
    localparam logic [TICK_W-1:0]        RST_POWER_ON  = 24'd30;
    localparam logic [TICK_W-1:0]        RST_MAX_RUN   = 24'd7200;
    localparam logic [TICK_W-1:0]        RST_REST      = 24'd600;
    localparam logic [TICK_W-1:0]        RST_MIN_OFF   = 24'd300;
    localparam logic signed [TEMP_W-1:0] RST_LOW_LIMIT  = -12'sd100;
    localparam logic signed [TEMP_W-1:0] RST_HIGH_LIMIT = 12'sd300;

    // One input word
    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [TEMP_W-1:0] temperature;
        logic signed [TEMP_W-1:0] stop_setting;
        logic signed [TEMP_W-1:0] start_setting;
    } t_item;

    // One result word
    typedef struct packed {
        logic              compressor_on;
        logic [MODE_W-1:0] mode;
        logic              setting_rejected;
        logic              report_valid;
        logic [RUN_W-1:0]  run_time_report;
    } t_result;

    // Current register contents
    typedef struct packed {
        logic [TICK_W-1:0]        power_on_wait;
        logic [TICK_W-1:0]        max_run;
        logic [TICK_W-1:0]        rest;
        logic [TICK_W-1:0]        min_off;
        logic signed [TEMP_W-1:0] low_limit;
        logic signed [TEMP_W-1:0] high_limit;
    } t_cfg;

    // Power-on wait rewrite, seen by the core in the write cycle
    typedef struct packed {
        logic              reload;
        logic [TICK_W-1:0] ticks;
    } t_cfg_evt;

endpackage

// ===== hdl/ccp_cfg_regs.sv =====
// Configuration register file of the compressor cycle protection block.
// Depends on ccp_pkg for register indexes, reset values and the t_cfg types.
module ccp_cfg_regs
    import ccp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output t_cfg_evt              o_cfg_evt
);

    t_cfg r_cfg;
    logic wr;

    // Always take a write
    assign o_cfg_ready = 1'b1;
    assign wr          = i_cfg_valid & o_cfg_ready;

    // Tell the core about a new power-on wait so it can reload its timer
    assign o_cfg_evt.reload = wr && (i_cfg_index == REG_POWER_ON);
    assign o_cfg_evt.ticks  = i_cfg_data[TICK_W-1:0];

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_on_wait <= RST_POWER_ON;
            r_cfg.max_run       <= RST_MAX_RUN;
            r_cfg.rest          <= RST_REST;
            r_cfg.min_off       <= RST_MIN_OFF;
            r_cfg.low_limit     <= RST_LOW_LIMIT;
            r_cfg.high_limit    <= RST_HIGH_LIMIT;
        end else if (wr) begin
            unique case (i_cfg_index)
                REG_POWER_ON:   r_cfg.power_on_wait <= i_cfg_data[TICK_W-1:0];
                REG_MAX_RUN:    r_cfg.max_run       <= i_cfg_data[TICK_W-1:0];
                REG_REST:       r_cfg.rest          <= i_cfg_data[TICK_W-1:0];
                REG_MIN_OFF:    r_cfg.min_off       <= i_cfg_data[TICK_W-1:0];
                REG_LOW_LIMIT:  r_cfg.low_limit     <= $signed(i_cfg_data[TEMP_W-1:0]);
                REG_HIGH_LIMIT: r_cfg.high_limit    <= $signed(i_cfg_data[TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/ccp_core.sv =====
// Controller state and next-state update for one word of the compressor block.
// Depends on ccp_pkg for codes, types and reset values.
module ccp_core
    import ccp_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_item    i_item,
    input  t_cfg     i_cfg,
    input  t_cfg_evt i_cfg_evt,
    output t_result  o_result
);

    // Clamp a tick count to the timer width
    function automatic logic [TIMER_WIDTH-1:0] sat_ticks(input logic [TICK_W-1:0] v);
        logic [31:0] v32;
        logic [31:0] lim32;
        v32   = 32'(v);
        lim32 = 32'({TIMER_WIDTH{1'b1}});
        return (v32 > lim32) ? TIMER_WIDTH'(lim32) : TIMER_WIDTH'(v32);
    endfunction

    logic [MODE_W-1:0]        r_mode,  n_mode;
    logic [TIMER_WIDTH-1:0]   r_tmr,   n_tmr;
    logic                     r_armed, n_armed;
    logic signed [TEMP_W-1:0] r_temp,  n_temp;
    logic                     r_flt,   n_flt;
    logic                     r_en,    n_en;
    logic                     r_band,  n_band;
    logic signed [TEMP_W-1:0] r_stop,  n_stop;
    logic signed [TEMP_W-1:0] r_start, n_start;
    logic [RUN_W-1:0]         r_run,   n_run;
    logic [RUN_W-1:0]         r_acc,   n_acc;

    logic [TIMER_WIDTH-1:0]   tmr_dec;
    logic                     do_eval;
    logic                     do_stop;
    logic                     do_start;
    logic [MODE_W-1:0]        stop_mode;
    logic [TICK_W-1:0]        stop_wait;
    logic [RUN_W:0]           acc_sum;
    logic                     rej;
    logic                     rvalid;
    logic [RUN_W-1:0]         rpt;

    // Timer counts down and stops at zero
    assign tmr_dec = (r_tmr != '0) ? r_tmr - 1'b1 : r_tmr;

    always_comb begin
        n_mode    = r_mode;
        n_tmr     = r_tmr;
        n_armed   = r_armed;
        n_temp    = r_temp;
        n_flt     = r_flt;
        n_en      = r_en;
        n_band    = r_band;
        n_stop    = r_stop;
        n_start   = r_start;
        n_run     = r_run;
        n_acc     = r_acc;
        do_eval   = 1'b0;
        do_stop   = 1'b0;
        do_start  = 1'b0;
        stop_mode = MODE_WAIT;
        stop_wait = i_cfg.min_off;
        acc_sum   = '0;
        rej       = 1'b0;
        rvalid    = 1'b0;
        rpt       = '0;

        // Apply the command
        unique case (i_item.command)
            CMD_TICK: begin
                if (r_mode == MODE_WORK && r_run != '1) begin
                    n_run = r_run + 1'b1;
                end
                if (r_armed) begin
                    n_tmr = tmr_dec;
                    if (tmr_dec == '0) begin
                        n_armed = 1'b0;
                        // Timer expiry
                        unique case (r_mode) inside
                            MODE_INIT, MODE_WAIT: begin
                                n_mode  = MODE_READY;
                                do_eval = 1'b1;
                            end
                            MODE_REST, MODE_FAULT: begin
                                n_mode  = MODE_CONT;
                                do_eval = 1'b1;
                            end
                            MODE_WORK: begin
                                do_stop   = 1'b1;
                                stop_mode = MODE_REST;
                                stop_wait = i_cfg.rest;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            CMD_TEMP: begin
                n_flt   = 1'b0;
                n_temp  = i_item.temperature;
                do_eval = 1'b1;
            end
            CMD_FAULT: begin
                n_flt = 1'b1;
                if (r_mode == MODE_WORK) begin
                    do_stop   = 1'b1;
                    stop_mode = MODE_FAULT;
                end
            end
            CMD_SET: begin
                if (i_item.stop_setting < i_cfg.low_limit ||
                    i_item.start_setting > i_cfg.high_limit) begin
                    rej = 1'b1;
                end else begin
                    n_band = 1'b1;
                    if (i_item.stop_setting != r_stop || i_item.start_setting != r_start) begin
                        n_stop  = i_item.stop_setting;
                        n_start = i_item.start_setting;
                        do_eval = 1'b1;
                    end
                end
            end
            CMD_LOCK: begin
                n_en = 1'b0;
                if (r_mode == MODE_WORK) begin
                    do_stop = 1'b1;
                end
            end
            CMD_UNLOCK: begin
                n_en    = 1'b1;
                do_eval = 1'b1;
            end
            CMD_REPORT: begin
                rvalid = 1'b1;
                rpt    = r_acc;
                n_acc  = '0;
            end
            default: ;
        endcase

        // Re-evaluate the thermostat band
        if (do_eval && n_en && n_band && !n_flt && n_mode != MODE_INIT) begin
            if (n_mode == MODE_WORK && n_temp <= n_stop) begin
                do_stop = 1'b1;
            end else if ((n_mode == MODE_READY && n_temp >= n_start) ||
                         (n_mode == MODE_CONT && n_temp > n_stop)) begin
                do_start = 1'b1;
            end
        end

        // Stop or start a run
        if (do_stop) begin
            acc_sum = {1'b0, n_acc} + {1'b0, n_run};
            n_acc   = acc_sum[RUN_W] ? '1 : acc_sum[RUN_W-1:0];
            n_run   = '0;
            n_mode  = stop_mode;
            n_tmr   = sat_ticks(stop_wait);
            n_armed = 1'b1;
        end else if (do_start) begin
            n_mode  = MODE_WORK;
            n_run   = '0;
            n_tmr   = sat_ticks(i_cfg.max_run);
            n_armed = 1'b1;
        end
    end

    // Hold state; advance on a word, or reload the power-on wait on a write during it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_INIT;
            r_tmr   <= sat_ticks(RST_POWER_ON);
            r_armed <= 1'b1;
            r_temp  <= '0;
            r_flt   <= 1'b0;
            r_en    <= 1'b0;
            r_band  <= 1'b0;
            r_stop  <= '0;
            r_start <= '0;
            r_run   <= '0;
            r_acc   <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_tmr   <= n_tmr;
            r_armed <= n_armed;
            r_temp  <= n_temp;
            r_flt   <= n_flt;
            r_en    <= n_en;
            r_band  <= n_band;
            r_stop  <= n_stop;
            r_start <= n_start;
            r_run   <= n_run;
            r_acc   <= n_acc;
        end else if (i_cfg_evt.reload && r_mode == MODE_INIT && r_armed) begin
            r_tmr <= sat_ticks(i_cfg_evt.ticks);
        end
    end

    assign o_result.compressor_on    = (n_mode == MODE_WORK);
    assign o_result.mode             = n_mode;
    assign o_result.setting_rejected = rej;
    assign o_result.report_valid     = rvalid;
    assign o_result.run_time_report  = rpt;

endmodule

// ===== hdl/compressor_cycle_protection_fsm.sv =====
// Top level of the compressor thermostat controller with anti-short-cycle protection.
// Depends on ccp_pkg, ccp_cfg_regs and ccp_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command word: tick,
//   temperature sample, sensor error, threshold setting, lock, unlock or report.
//   Every word gives exactly one result word on the output channel
//   (o_out_valid / i_out_stall): compressor drive, mode, setting reject flag
//   and the run time report.
//   A word is taken into an input register, processed by the controller update
//   once the output register can take it, and written to the output register.
//   One word per cycle is sustained while the receiver does not stall.
//   When the receiver stalls, the output register holds its word and the input
//   register can still take one more word; o_in_stall rises only when both are
//   full.
//   Configuration writes (i_cfg_valid / o_cfg_ready, ready always high) must be
//   made by the user while the block is idle; the block does not enforce this.
//   Rewriting the power-on wait during that wait restarts it with the new value.
//   Reset (i_rst_n low, synchronous) empties both registers, loads the
//   register defaults and starts the power-on wait in init mode.
module compressor_cycle_protection_fsm
    import ccp_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input words
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_command,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic signed [TEMP_W-1:0] i_stop_setting,
    input  logic signed [TEMP_W-1:0] i_start_setting,
    // Result words
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_compressor_on,
    output logic [MODE_W-1:0]        o_mode,
    output logic                     o_setting_rejected,
    output logic                     o_report_valid,
    output logic [RUN_W-1:0]         o_run_time_report,
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    t_cfg     cfg;
    t_cfg_evt cfg_evt;
    t_item    in_item;
    t_result  core_res;

    logic     r_in_vld;
    t_item    r_in_item;
    logic     r_out_vld;
    t_result  r_out;

    logic     can_out;
    logic     proc;
    logic     in_acc;

    ccp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_cfg_evt   (cfg_evt)
    );

    ccp_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (proc),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .i_cfg_evt (cfg_evt),
        .o_result  (core_res)
    );

    // Handshake: output register frees when empty or taken
    assign can_out    = !r_out_vld || !i_out_stall;
    assign proc       = r_in_vld && can_out;
    assign o_in_stall = r_in_vld && !can_out;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign in_item.command       = i_command;
    assign in_item.temperature   = i_temperature;
    assign in_item.stop_setting  = i_stop_setting;
    assign in_item.start_setting = i_start_setting;

    // Valid flags of the two registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (proc) begin
                r_in_vld <= 1'b0;
            end
            if (can_out) begin
                r_out_vld <= proc;
            end
        end
    end

    // Payload: capture input word, hold result while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_item <= in_item;
        end
        if (proc) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_compressor_on    = r_out.compressor_on;
    assign o_mode             = r_out.mode;
    assign o_setting_rejected = r_out.setting_rejected;
    assign o_report_valid     = r_out.report_valid;
    assign o_run_time_report  = r_out.run_time_report;

    // Compressor drive follows the work mode
    a_drive_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_compressor_on == (o_mode == MODE_WORK)))
        else $error("compressor drive does not match mode");

    // Report value only on a report word
    a_report_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_report_valid) |-> (o_run_time_report == '0))
        else $error("run time report outside a report word");

    // A word cannot be both a rejected setting and a report
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_setting_rejected && o_report_valid))
        else $error("reject and report on the same word");

    // A processed word shows up in the output register on the next edge
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> o_out_valid)
        else $error("processed word lost");

endmodule
